### rtl/core/krc_pkg.sv
// ----------------------------------------------------------------------------
// krc_pkg
// Shared types for the rank correlation engine.
// ----------------------------------------------------------------------------
package krc_pkg;

	// control bits that travel with a pair down the cell chain
	typedef struct packed {
		logic act;   // slot holds a request
		logic keep;  // pair was taken into the store
		logic last;  // final pair of the set
	} tok_ctl_t;

	localparam int unsigned OutW = 80;

endpackage

### rtl/core/krc_cell.sv
// ----------------------------------------------------------------------------
// krc_cell
// One store slot: holds a pair, compares passing pairs, forwards the token.
// ----------------------------------------------------------------------------
module krc_cell #(
	parameter int unsigned IDX  = 0,
	parameter int unsigned SW   = 16,
	parameter int unsigned IDXW = 8,
	parameter int unsigned TW   = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  krc_pkg::tok_ctl_t ctl_in,
	input  logic [IDXW-1:0]   idx_in,
	input  logic [SW-1:0]     x_in,
	input  logic [SW-1:0]     y_in,
	input  logic [TW-1:0]     c_in,
	input  logic [TW-1:0]     d_in,
	input  logic [TW-1:0]     tx_in,
	input  logic [TW-1:0]     ty_in,
	output krc_pkg::tok_ctl_t ctl_out,
	output logic [IDXW-1:0]   idx_out,
	output logic [SW-1:0]     x_out,
	output logic [SW-1:0]     y_out,
	output logic [TW-1:0]     c_out,
	output logic [TW-1:0]     d_out,
	output logic [TW-1:0]     tx_out,
	output logic [TW-1:0]     ty_out
);

	logic [SW-1:0] sx_q, sy_q;
	logic          live, cmp, wr, conc, disc;

	assign live = ctl_in.act & ctl_in.keep;
	// slot holds an earlier pair of the set only if its index is below the token's
	assign cmp  = live & (idx_in > IDXW'(IDX));
	assign wr   = live & (idx_in == IDXW'(IDX));
	assign conc = (sx_q > x_in && sy_q > y_in) || (sx_q < x_in && sy_q < y_in);
	assign disc = (sx_q > x_in && sy_q < y_in) || (sx_q < x_in && sy_q > y_in);

	always_ff @(posedge clk) begin
		if (wr) begin
			sx_q <= x_in;
			sy_q <= y_in;
		end
		idx_out <= idx_in;
		x_out   <= x_in;
		y_out   <= y_in;
		c_out   <= c_in  + TW'(cmp & conc);
		d_out   <= d_in  + TW'(cmp & disc);
		tx_out  <= tx_in + TW'(cmp & (sx_q == x_in));
		ty_out  <= ty_in + TW'(cmp & (sy_q == y_in));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_out <= '0;
		end else begin
			ctl_out <= ctl_in;
		end
	end

endmodule

### rtl/core/krc_math.sv
// ----------------------------------------------------------------------------
// krc_math
// Serial divide, plus a square root in tau-b mode, producing the saturated Q1.15 tau.
// ----------------------------------------------------------------------------
module krc_math #(
	parameter int unsigned CW = 15
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          tieb,
	input  logic          neg,
	input  logic [CW-1:0] mag,
	input  logic [CW-1:0] n3,
	input  logic [CW-1:0] a,
	input  logic [CW-1:0] b,
	output logic          done,
	output logic [15:0]   tau
);

	localparam int unsigned DW  = 2 * CW + 30;
	localparam int unsigned DCW = $clog2(DW + 1);

	typedef enum logic [2:0] {M_IDLE, M_MUL, M_LOAD, M_DIV, M_SQRT, M_DONE} mstate_t;

	mstate_t          state_q;
	logic             tieb_q, neg_q;
	logic [CW-1:0]    mag_q, n3_q, a_q, b_q;
	logic [2*CW-1:0]  num_q, den_q;
	logic [DW-1:0]    dvd_q, quot_q;
	logic [2*CW:0]    rem_q;
	logic [DCW-1:0]   cnt_q;
	logic [31:0]      v_q, res_q, bit_q;

	logic [2*CW:0]    rem_sh;
	logic             qbit;
	logic [31:0]      rb;
	logic [DW-1:0]    mc;
	logic [15:0]      tau_n;

	assign rem_sh = {rem_q[2*CW-1:0], dvd_q[DW-1]};
	assign qbit   = rem_sh >= {1'b0, den_q};
	assign rb     = res_q + bit_q;
	assign mc     = tieb_q ? DW'(res_q) : quot_q;

	always_comb begin
		if (neg_q) begin
			tau_n = (mc > DW'(32768)) ? 16'h8000 : (~mc[15:0]) + 16'd1;
		end else begin
			tau_n = (mc > DW'(32767)) ? 16'h7fff : mc[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
		end else begin
			case (state_q)
				M_IDLE: begin
					if (start) begin
						state_q <= M_MUL;
					end
				end
				M_MUL:  state_q <= M_LOAD;
				M_LOAD: state_q <= M_DIV;
				M_DIV: begin
					if (cnt_q == DCW'(1)) begin
						state_q <= tieb_q ? M_SQRT : M_DONE;
					end
				end
				M_SQRT: begin
					if (bit_q == '0) begin
						state_q <= M_DONE;
					end
				end
				M_DONE:  state_q <= M_IDLE;
				default: state_q <= M_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			M_IDLE: begin
				tieb_q <= tieb;
				neg_q  <= neg;
				mag_q  <= mag;
				n3_q   <= n3;
				a_q    <= a;
				b_q    <= b;
			end
			M_MUL: begin
				num_q <= tieb_q ? mag_q * mag_q : (2*CW)'(mag_q);
				den_q <= tieb_q ? a_q * b_q : (2*CW)'(n3_q);
			end
			M_LOAD: begin
				dvd_q <= DW'(num_q) << (tieb_q ? 30 : 15);
				rem_q <= '0;
				cnt_q <= DCW'(DW);
			end
			M_DIV: begin
				dvd_q  <= dvd_q << 1;
				rem_q  <= qbit ? rem_sh - {1'b0, den_q} : rem_sh;
				quot_q <= {quot_q[DW-2:0], qbit};
				cnt_q  <= cnt_q - DCW'(1);
				// integer part of the ratio is capped at one
				v_q    <= {1'b0, |{quot_q[DW-2:29]}, quot_q[28:0], qbit};
				res_q  <= '0;
				bit_q  <= 32'h4000_0000;
			end
			M_SQRT: begin
				if (bit_q != '0) begin
					if (v_q >= rb) begin
						v_q   <= v_q - rb;
						res_q <= (res_q >> 1) + bit_q;
					end else begin
						res_q <= res_q >> 1;
					end
					bit_q <= bit_q >> 2;
				end
			end
			M_DONE: begin
			end
			default: begin
			end
		endcase
	end

	assign done = (state_q == M_DONE);
	assign tau  = tau_n;

endmodule

### rtl/core/kendall_rank_correlation.sv
// ----------------------------------------------------------------------------
// kendall_rank_correlation
// Kendall tau-a / tau-b engine over a chain of pair-store cells.
// ----------------------------------------------------------------------------
// channel   dir  handshake          payload
// s_*       in   tvalid/tready      tdata = x_value, y_value; tlast = last_item
// m_*       out  tvalid/tready      tdata = result fields (see port)
// cfg_*     in   wr_en              wr_data = tie_corrected
//
// One pair is taken per cycle while a set arrives. Each pair walks the
// MAX_PAIRS cell chain one cell a cycle; once the last pair leaves it,
// the result passes two prep states, then a prepare and a load state,
// 2*CW+30 divide steps, in tau-b the square root, and a done state; a
// zero denominator skips the math. No pair is taken from the last
// pair of a set until its result is taken. Reset is asynchronous and leaves
// tie_corrected at 1; the store needs no clearing. A stalled result holds.
// ----------------------------------------------------------------------------
module kendall_rank_correlation #(
	parameter int unsigned MAX_PAIRS    = 256,
	parameter int unsigned SAMPLE_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // x_value[15:0], y_value[31:16]
	input  logic        s_tlast,   // last_item
	output logic        m_tvalid,
	input  logic        m_tready,
	// score_difference[15:0], ties_in_x[30:16], ties_in_y[45:31],
	// pair_total[60:46], tau_fixed[76:61], undefined_flag[77], overflow_flag[78]
	output logic [79:0] m_tdata,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data
);

	localparam int unsigned SW   = (SAMPLE_WIDTH < 16) ? SAMPLE_WIDTH : 16;
	localparam int unsigned IDXW = $clog2(MAX_PAIRS);
	localparam int unsigned IW   = $clog2(MAX_PAIRS + 1);
	localparam int unsigned TW   = $clog2(MAX_PAIRS);
	localparam int unsigned CW   = $clog2(MAX_PAIRS * (MAX_PAIRS - 1) / 2 + 1);

	typedef enum logic [2:0] {T_RUN, T_DRAIN, T_PREP, T_PREP2, T_MATH, T_OUT} tstate_t;

	tstate_t            state_q;
	logic               tie_q;
	logic [IW-1:0]      cnt_q, n_q;
	logic               ovf_q, ovf_fin_q;
	logic [CW-1:0]      acc_c_q, acc_d_q, acc_x_q, acc_y_q, n3_q;
	logic signed [CW:0] s_q;
	logic [79:0]        out_q;

	krc_pkg::tok_ctl_t  ctl   [0:MAX_PAIRS];
	logic [IDXW-1:0]    idx   [0:MAX_PAIRS];
	logic [SW-1:0]      xs    [0:MAX_PAIRS];
	logic [SW-1:0]      ys    [0:MAX_PAIRS];
	logic [TW-1:0]      cs    [0:MAX_PAIRS];
	logic [TW-1:0]      ds    [0:MAX_PAIRS];
	logic [TW-1:0]      txs   [0:MAX_PAIRS];
	logic [TW-1:0]      tys   [0:MAX_PAIRS];

	logic               acc_in, keep;
	logic [CW:0]        mag;
	logic [CW-1:0]      a, b;
	logic               undef;
	logic               m_done;
	logic [15:0]        m_tau;
	krc_pkg::tok_ctl_t  ex;

	assign s_tready = (state_q == T_RUN);
	assign acc_in   = s_tvalid & s_tready;
	assign keep     = cnt_q < IW'(MAX_PAIRS);

	assign ctl[0].act  = acc_in;
	assign ctl[0].keep = keep;
	assign ctl[0].last = s_tlast;
	assign idx[0]      = IDXW'(cnt_q);
	assign xs[0]       = s_tdata[SW-1:0];
	assign ys[0]       = s_tdata[16+SW-1:16];
	assign cs[0]       = '0;
	assign ds[0]       = '0;
	assign txs[0]      = '0;
	assign tys[0]      = '0;

	for (genvar i = 0; i < MAX_PAIRS; i++) begin : g_cell
		krc_cell #(.IDX(i), .SW(SW), .IDXW(IDXW), .TW(TW)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.ctl_in(ctl[i]), .idx_in(idx[i]), .x_in(xs[i]), .y_in(ys[i]),
			.c_in(cs[i]), .d_in(ds[i]), .tx_in(txs[i]), .ty_in(tys[i]),
			.ctl_out(ctl[i+1]), .idx_out(idx[i+1]), .x_out(xs[i+1]), .y_out(ys[i+1]),
			.c_out(cs[i+1]), .d_out(ds[i+1]), .tx_out(txs[i+1]), .ty_out(tys[i+1])
		);
	end

	assign ex    = ctl[MAX_PAIRS];
	assign mag   = s_q[CW] ? -s_q : s_q;
	assign a     = n3_q - acc_x_q;
	assign b     = n3_q - acc_y_q;
	assign undef = tie_q ? (a == '0 || b == '0) : (n3_q == '0);

	krc_math #(.CW(CW)) u_math (
		.clk(clk), .arst_n(arst_n),
		.start(state_q == T_PREP2 && !undef),
		.tieb(tie_q), .neg(s_q[CW]), .mag(mag[CW-1:0]), .n3(n3_q), .a(a), .b(b),
		.done(m_done), .tau(m_tau)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_RUN;
			tie_q   <= 1'b1;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			acc_c_q <= '0;
			acc_d_q <= '0;
			acc_x_q <= '0;
			acc_y_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				tie_q <= cfg_wr_data;
			end
			if (ex.act && ex.keep) begin
				acc_c_q <= acc_c_q + CW'(cs[MAX_PAIRS]);
				acc_d_q <= acc_d_q + CW'(ds[MAX_PAIRS]);
				acc_x_q <= acc_x_q + CW'(txs[MAX_PAIRS]);
				acc_y_q <= acc_y_q + CW'(tys[MAX_PAIRS]);
			end
			case (state_q)
				T_RUN: begin
					if (acc_in) begin
						if (s_tlast) begin
							n_q       <= cnt_q + IW'(keep);
							ovf_fin_q <= ovf_q | ~keep;
							cnt_q     <= '0;
							ovf_q     <= 1'b0;
							state_q   <= T_DRAIN;
						end else begin
							cnt_q <= cnt_q + IW'(keep);
							ovf_q <= ovf_q | ~keep;
						end
					end
				end
				T_DRAIN: begin
					if (ex.act && ex.last) begin
						state_q <= T_PREP;
					end
				end
				T_PREP: begin
					// n(n-1) needs twice the count width before halving
					n3_q    <= CW'(((2*IW)'(n_q) * (2*IW)'(n_q - IW'(n_q != '0))) >> 1);
					s_q     <= $signed({1'b0, acc_c_q}) - $signed({1'b0, acc_d_q});
					state_q <= T_PREP2;
				end
				T_PREP2: begin
					out_q   <= {1'b0, ovf_fin_q, 1'b1, 16'd0, 15'(n3_q), 15'(acc_y_q),
						15'(acc_x_q), 16'(s_q)};
					state_q <= undef ? T_OUT : T_MATH;
				end
				T_MATH: begin
					if (m_done) begin
						out_q[77]    <= 1'b0;
						out_q[76:61] <= m_tau;
						state_q      <= T_OUT;
					end
				end
				T_OUT: begin
					if (m_tready) begin
						acc_c_q <= '0;
						acc_d_q <= '0;
						acc_x_q <= '0;
						acc_y_q <= '0;
						state_q <= T_RUN;
					end
				end
				default: state_q <= T_RUN;
			endcase
		end
	end

	assign m_tvalid = (state_q == T_OUT);
	assign m_tdata  = out_q;

	a_no_req_during_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready) else $error("request taken while result pending");
	a_count_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_in && s_tlast) |=> (cnt_q == '0 && state_q == T_DRAIN))
		else $error("set not closed after last pair");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= IW'(MAX_PAIRS)) else $error("store count beyond capacity");
	a_chain_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == T_OUT) |-> !ex.act) else $error("pair left chain after set end");

endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for kendall_rank_correlation: drives sets of sample
// pairs under varied idle and stall patterns in both tau modes, predicts
// each set's counts and tau, and compares every result field.
// ----------------------------------------------------------------------------
module testbench;

	typedef struct packed {
		logic        ovf;
		logic        undef;
		logic [15:0] tau;
		logic [14:0] total;
		logic [14:0] ty;
		logic [14:0] tx;
		logic [15:0] diff;
	} corr_result_t;

	localparam int unsigned DEPTH      = 256;
	localparam int unsigned SETTLE     = 700;
	localparam int unsigned CYCLE_CAP  = 3000000;
	localparam bit          MODE_TAU_A = 1'b0;
	localparam bit          MODE_TAU_B = 1'b1;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [79:0] m_tdata;
	logic        cfg_wr_en = 1'b0;
	logic        cfg_wr_data = 1'b0;

	// predictor state
	logic [15:0]  px [DEPTH];
	logic [15:0]  py [DEPTH];
	int unsigned  stored_n, conc_n, disc_n, xtie_n, ytie_n;
	bit           dropped;
	bit           tau_b_mode;

	corr_result_t pending_results[$];
	int unsigned  fail_count = 0;
	int unsigned  cycle_count = 0;
	int unsigned  send_idle_pct = 0;
	int unsigned  recv_stall_pct = 0;

	always #10 clk = ~clk;

	kendall_rank_correlation u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	// floor(num * 2^30 / den), integer part capped at 1
	function automatic longint unsigned frac_q30(longint unsigned num, longint unsigned den);
		longint unsigned q, r, f;
		q = num / den;
		r = num % den;
		f = 0;
		if (q > 1) q = 1;
		for (int i = 0; i < 30; i++) begin
			r = r << 1;
			f = f << 1;
			if (r >= den) begin
				r = r - den;
				f = f | 1;
			end
		end
		return (q << 30) + f;
	endfunction

	function automatic longint unsigned isqrt64(longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic void clear_set();
		stored_n = 0; conc_n = 0; disc_n = 0; xtie_n = 0; ytie_n = 0;
		dropped = 0;
	endfunction

	// fold one accepted request into the running counts; on the last one, queue the expected result
	function automatic void absorb_pair(logic [15:0] xn, logic [15:0] yn, logic lst);
		longint unsigned n3, mag, m, a, b;
		longint s;
		bit undef;
		corr_result_t r;
		m = 0;
		undef = 0;
		if (stored_n < DEPTH) begin
			for (int i = 0; i < stored_n; i++) begin
				if ((px[i] > xn && py[i] > yn) || (px[i] < xn && py[i] < yn))
					conc_n++;
				else if ((px[i] > xn && py[i] < yn) || (px[i] < xn && py[i] > yn))
					disc_n++;
				if (px[i] == xn) xtie_n++;
				if (py[i] == yn) ytie_n++;
			end
			px[stored_n] = xn;
			py[stored_n] = yn;
			stored_n++;
		end else begin
			dropped = 1;
		end
		if (!lst) return;
		n3 = (stored_n > 0) ? longint'(stored_n) * (stored_n - 1) / 2 : 0;
		s = longint'(conc_n) - longint'(disc_n);
		mag = (s < 0) ? -s : s;
		if (!tau_b_mode) begin
			if (n3 == 0) undef = 1;
			else m = (mag << 15) / n3;
		end else begin
			a = n3 - xtie_n;
			b = n3 - ytie_n;
			if (a == 0 || b == 0) undef = 1;
			else m = isqrt64(frac_q30(mag * mag, a * b));
		end
		if (undef) r.tau = '0;
		else if (s < 0) r.tau = 16'(-((m > 32768) ? 32768 : m));
		else r.tau = 16'((m > 32767) ? 32767 : m);
		r.diff  = s[15:0];
		r.tx    = xtie_n[14:0];
		r.ty    = ytie_n[14:0];
		r.total = n3[14:0];
		r.undef = undef;
		r.ovf   = dropped;
		pending_results.insert(pending_results.size(), r);
		clear_set();
	endfunction

	// called at a falling edge, returns at a falling edge
	task automatic send_pair(logic [15:0] xv, logic [15:0] yv, logic lst);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {yv, xv};
		s_tlast  <= lst;
		do @(posedge clk); while (!s_tready);
		absorb_pair(xv, yv, lst);
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_mode(bit mode);
		drain();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= mode;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
		tau_b_mode = mode;
		@(negedge clk);
	endtask

	task automatic send_ramp(int unsigned len, bit down);
		for (int i = 0; i < len; i++)
			send_pair(16'(i * 1000), down ? 16'(65535 - i * 7) : 16'(i * 3), i == len - 1);
	endtask

	task automatic test_directed(bit mode);
		write_mode(mode);
		send_pair(16'h1234, 16'h5678, 1'b1);           // lone pair
		send_pair(16'd9, 16'd3, 1'b0);                 // all x and y equal
		send_pair(16'd9, 16'd3, 1'b1);
		send_ramp(4, 1'b0);                            // tau +1
		send_ramp(5, 1'b1);                            // tau -1
		send_pair(16'h0000, 16'hFFFF, 1'b0);           // field extremes
		send_pair(16'hFFFF, 16'h0000, 1'b0);
		send_pair(16'h0000, 16'h0000, 1'b0);
		send_pair(16'hFFFF, 16'hFFFF, 1'b1);
		send_pair(16'd5, 16'd1, 1'b0);                 // x all tied, y varies
		send_pair(16'd5, 16'd2, 1'b0);
		send_pair(16'd5, 16'd7, 1'b1);
	endtask

	// store fills, extra requests dropped but the set still reports
	task automatic test_overflow();
		write_mode(MODE_TAU_B);
		for (int i = 0; i < DEPTH + 3; i++)
			send_pair(16'($urandom), 16'($urandom_range(0, 40)), i == DEPTH + 2);
		drain();
	endtask

	function automatic logic [15:0] rand_sample(int unsigned spread);
		case (spread)
			0: return 16'($urandom_range(0, 3));
			1: return 16'($urandom_range(0, 20));
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic test_random(int unsigned items, int unsigned idle, int unsigned stall,
	                           bit mode);
		int unsigned sent, len, spread;
		write_mode(mode);
		send_idle_pct  = idle;
		recv_stall_pct = stall;
		sent = 0;
		while (sent < items) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
			spread = $urandom_range(2);
			for (int i = 0; i < len; i++)
				send_pair(rand_sample(spread), rand_sample(spread), i == len - 1);
			sent += len;
		end
		drain();
	endtask

	// receiver side
	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin
		corr_result_t got, want;
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_CAP) begin
			$display("FAILURE");
			$finish;
		end
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[78:0];
			if (pending_results.size() == 0) begin
				$error("unexpected result %h", m_tdata);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (got.diff !== want.diff) begin
					$error("score_difference exp %0d got %0d", $signed(want.diff), $signed(got.diff));
					fail_count++;
				end
				if (got.tx !== want.tx) begin
					$error("ties_in_x exp %0d got %0d", want.tx, got.tx);
					fail_count++;
				end
				if (got.ty !== want.ty) begin
					$error("ties_in_y exp %0d got %0d", want.ty, got.ty);
					fail_count++;
				end
				if (got.total !== want.total) begin
					$error("pair_total exp %0d got %0d", want.total, got.total);
					fail_count++;
				end
				if (got.tau !== want.tau) begin
					$error("tau_fixed exp %0d got %0d", $signed(want.tau), $signed(got.tau));
					fail_count++;
				end
				if (got.undef !== want.undef) begin
					$error("undefined_flag exp %0b got %0b", want.undef, got.undef);
					fail_count++;
				end
				if (got.ovf !== want.ovf) begin
					$error("overflow_flag exp %0b got %0b", want.ovf, got.ovf);
					fail_count++;
				end
			end
		end
	end

	initial begin
		clear_set();
		tau_b_mode = MODE_TAU_B;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed(MODE_TAU_B);
		test_directed(MODE_TAU_A);
		test_overflow();
		test_random(40, 0, 0, MODE_TAU_B);
		test_random(40, 48, 0, MODE_TAU_A);
		test_random(40, 0, 48, MODE_TAU_B);
		test_random(40, 19, 19, MODE_TAU_A);
		drain();
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
